// File: rtl/ssil_pkg.sv
// Shared constants, the gap table and widths for the shell-sort index list.
package ssil_pkg;

    localparam int DEPTH      = 64;
    localparam int VALUE_BITS = 20;
    localparam int AW         = $clog2(DEPTH);
    localparam int CW         = $clog2(DEPTH + 1);
    localparam int GAP_COUNT  = 12;
    localparam int KW         = $clog2(GAP_COUNT + 1);
    localparam int GAP_BITS   = 21;

    typedef logic [VALUE_BITS-1:0] t_value;
    typedef logic [AW-1:0]         t_addr;
    typedef logic [CW-1:0]         t_count;

    // Descending gap sequence, one entry per pass.
    function automatic logic [GAP_BITS-1:0] gap_at(input logic [KW-1:0] k);
        logic [GAP_BITS-1:0] g;
        unique case (k)
            KW'(0):  g = GAP_BITS'(1391376);
            KW'(1):  g = GAP_BITS'(13776);
            KW'(2):  g = GAP_BITS'(4592);
            KW'(3):  g = GAP_BITS'(1968);
            KW'(4):  g = GAP_BITS'(861);
            KW'(5):  g = GAP_BITS'(336);
            KW'(6):  g = GAP_BITS'(112);
            KW'(7):  g = GAP_BITS'(48);
            KW'(8):  g = GAP_BITS'(21);
            KW'(9):  g = GAP_BITS'(7);
            KW'(10): g = GAP_BITS'(3);
            KW'(11): g = GAP_BITS'(1);
            default: g = '0;
        endcase
        return g;
    endfunction

endpackage

// File: rtl/ssil_ram.sv
// Value buffer: one write port, one read port with registered read data.
module ssil_ram (
    input  logic            i_clk,
    input  logic            i_we,
    input  ssil_pkg::t_addr i_waddr,
    input  ssil_pkg::t_value i_wdata,
    input  ssil_pkg::t_addr i_raddr,
    output ssil_pkg::t_value o_rdata
);

    ssil_pkg::t_value r_mem [ssil_pkg::DEPTH];
    ssil_pkg::t_value r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// File: rtl/shell_sort_index_list.sv
// Shell-sort index list. Values arrive one beat per cycle and are stored in a
// 64-entry buffer; values beyond that are dropped and flag overflow on every
// result of the set. The beat with last set starts a Shell sort over the
// stored values (gaps from a fixed descending table, gaps at or above the
// count skipped), and the block then emits every value in ascending order,
// final one flagged. The input is stalled from the last beat until the final
// result has been loaded into the output register. All work goes through one
// buffer memory with one read and one write port: the sort steps through the
// gap table entry by entry, and each insertion step loads the held value and
// compares it, with a further compare and write per element moved; emission
// loads the values one at a time into the output register, holding while the
// output is stalled, and the work is dominated by the compare-and-move loop.
module shell_sort_index_list (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  ssil_pkg::t_value      i_value,
    input  logic                  i_last,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output ssil_pkg::t_value      o_sorted_value,
    output logic                  o_final_res,
    output logic                  o_overflow
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_GAP  = 3'd1;
    localparam logic [2:0] ST_LDH  = 3'd2;
    localparam logic [2:0] ST_CMP  = 3'd3;
    localparam logic [2:0] ST_WRH  = 3'd4;
    localparam logic [2:0] ST_ERD  = 3'd5;
    localparam logic [2:0] ST_EMIT = 3'd6;

    localparam int CW = ssil_pkg::CW;
    localparam int AW = ssil_pkg::AW;
    localparam int KW = ssil_pkg::KW;

    logic [2:0]                r_state, n_state;
    ssil_pkg::t_count          r_count, n_count;
    logic                      r_dropped, n_dropped;
    logic [KW-1:0]             r_k, n_k;
    ssil_pkg::t_count          r_gap, n_gap;
    ssil_pkg::t_count          r_i, n_i;
    ssil_pkg::t_count          r_j, n_j;
    ssil_pkg::t_value          r_held, n_held;
    logic                      r_out_valid, n_out_valid;
    ssil_pkg::t_value          r_out_value, n_out_value;
    logic                      r_out_final, n_out_final;
    logic                      r_out_ovf, n_out_ovf;

    logic                      we;
    ssil_pkg::t_addr           waddr;
    ssil_pkg::t_value          wdata;
    ssil_pkg::t_addr           raddr;
    ssil_pkg::t_value          rdata;

    logic [ssil_pkg::GAP_BITS-1:0] gap_full;
    ssil_pkg::t_count          j_next;
    ssil_pkg::t_count          i_next;
    logic                      accept;
    logic                      can_load;

    ssil_ram u_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_waddr (waddr),
        .i_wdata (wdata),
        .i_raddr (raddr),
        .o_rdata (rdata)
    );

    assign accept   = i_in_valid && (r_state == ST_IDLE);
    assign gap_full = ssil_pkg::gap_at(r_k);
    assign j_next   = r_j - r_gap;
    assign i_next   = r_i + CW'(1);
    assign can_load = !r_out_valid || !i_out_stall;

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_dropped   = r_dropped;
        n_k         = r_k;
        n_gap       = r_gap;
        n_i         = r_i;
        n_j         = r_j;
        n_held      = r_held;
        n_out_valid = r_out_valid && i_out_stall;
        n_out_value = r_out_value;
        n_out_final = r_out_final;
        n_out_ovf   = r_out_ovf;
        we          = 1'b0;
        waddr       = r_j[AW-1:0];
        wdata       = r_held;
        raddr       = r_i[AW-1:0];

        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    if (r_count < CW'(ssil_pkg::DEPTH)) begin
                        we      = 1'b1;
                        waddr   = r_count[AW-1:0];
                        wdata   = i_value;
                        n_count = r_count + CW'(1);
                    end else begin
                        n_dropped = 1'b1;
                    end
                    if (i_last) begin
                        n_k     = '0;
                        n_state = ST_GAP;
                    end
                end
            end
            ST_GAP: begin
                if (r_k == KW'(ssil_pkg::GAP_COUNT)) begin
                    n_i     = '0;
                    n_state = ST_ERD;
                end else begin
                    n_k = r_k + KW'(1);
                    if (gap_full < ssil_pkg::GAP_BITS'(r_count)) begin
                        n_gap   = gap_full[CW-1:0];
                        n_i     = gap_full[CW-1:0];
                        raddr   = gap_full[AW-1:0];
                        n_state = ST_LDH;
                    end
                end
            end
            ST_LDH: begin
                // rdata is buf[i]: hold it and fetch buf[i-gap]
                n_held  = rdata;
                n_j     = r_i;
                raddr   = AW'(r_i - r_gap);
                n_state = ST_CMP;
            end
            ST_CMP: begin
                if (rdata > r_held) begin
                    we    = 1'b1;
                    waddr = r_j[AW-1:0];
                    wdata = rdata;
                    n_j   = j_next;
                    if (j_next >= r_gap) begin
                        raddr = AW'(j_next - r_gap);
                    end else begin
                        n_state = ST_WRH;
                    end
                end else begin
                    we    = 1'b1;
                    n_i   = i_next;
                    raddr = i_next[AW-1:0];
                    n_state = (i_next < r_count) ? ST_LDH : ST_GAP;
                end
            end
            ST_WRH: begin
                we    = 1'b1;
                n_i   = i_next;
                raddr = i_next[AW-1:0];
                n_state = (i_next < r_count) ? ST_LDH : ST_GAP;
            end
            ST_ERD: begin
                n_state = ST_EMIT;
            end
            ST_EMIT: begin
                // keep refetching the same entry while the output is held
                if (can_load) begin
                    raddr       = i_next[AW-1:0];
                    n_i         = i_next;
                    n_out_valid = 1'b1;
                    n_out_value = rdata;
                    n_out_final = (i_next == r_count);
                    n_out_ovf   = r_dropped;
                    if (i_next == r_count) begin
                        n_count   = '0;
                        n_dropped = 1'b0;
                        n_state   = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_dropped   <= 1'b0;
            r_k         <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_dropped   <= n_dropped;
            r_k         <= n_k;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_gap       <= n_gap;
        r_i         <= n_i;
        r_j         <= n_j;
        r_held      <= n_held;
        r_out_value <= n_out_value;
        r_out_final <= n_out_final;
        r_out_ovf   <= n_out_ovf;
    end

    assign o_in_stall     = (r_state != ST_IDLE);
    assign o_out_valid    = r_out_valid;
    assign o_sorted_value = r_out_value;
    assign o_final_res    = r_out_final;
    assign o_overflow     = r_out_ovf;

endmodule
